[src/ogic_pkg.sv]
// Shared types and constants for the online grid island counter.
`timescale 1ns / 1ps
`default_nettype none
package ogic_pkg;
  localparam int unsigned MaxRowsDef = 32;
  localparam int unsigned MaxColsDef = 32;
  localparam int unsigned CfgW = 6;
  localparam int unsigned CountW = 11;
  localparam logic CfgRows = 1'b0;
  localparam logic CfgCols = 1'b1;

  typedef struct packed {
    logic [4:0] row;
    logic [4:0] col;
    logic       oor;
  } ogic_cmd_t;
endpackage
`default_nettype wire

[src/ogic_ram.sv]
// Generic single-port RAM with registered read.
`timescale 1ns / 1ps
`default_nettype none
module ogic_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] addr_i,
  input  wire logic [Width-1:0]         wdata_i,
  output logic      [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];
  always_ff @(posedge clk_i) begin
    if (we_i) mem_q[addr_i] <= wdata_i;
    rdata_o <= mem_q[addr_i];
  end
endmodule
`default_nettype wire

[src/ogic_front.sv]
// Front end: range check of incoming cells and a two-entry command queue.
`timescale 1ns / 1ps
`default_nettype none
module ogic_front import ogic_pkg::*; #(
  parameter int unsigned MaxRows = MaxRowsDef,
  parameter int unsigned MaxCols = MaxColsDef
) (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic [CfgW-1:0] rows_i,
  input  wire logic [CfgW-1:0] cols_i,
  input  wire logic            in_valid_i,
  output logic                 in_stall_o,
  input  wire logic [4:0]      row_i,
  input  wire logic [4:0]      col_i,
  output logic                 cmd_valid_o,
  input  wire logic            cmd_pop_i,
  output ogic_cmd_t            cmd_o
);
  localparam int unsigned RowLimW = $clog2(MaxRows + 1) > CfgW ? $clog2(MaxRows + 1) : CfgW;
  localparam int unsigned ColLimW = $clog2(MaxCols + 1) > CfgW ? $clog2(MaxCols + 1) : CfgW;
  logic [RowLimW-1:0] rlim;
  logic [ColLimW-1:0] clim;
  ogic_cmd_t q_q [2];
  logic [1:0] cnt_q;
  logic       rd_q, wr_q;
  logic       push;
  ogic_cmd_t  c;

  always_comb begin
    rlim = (RowLimW'(rows_i) > RowLimW'(MaxRows)) ? RowLimW'(MaxRows) : RowLimW'(rows_i);
    clim = (ColLimW'(cols_i) > ColLimW'(MaxCols)) ? ColLimW'(MaxCols) : ColLimW'(cols_i);
    c.row = row_i;
    c.col = col_i;
    c.oor = (RowLimW'(row_i) >= rlim) || (ColLimW'(col_i) >= clim);
  end

  assign in_stall_o  = cnt_q[1];
  assign push        = in_valid_i && !cnt_q[1];
  assign cmd_valid_o = cnt_q != 2'd0;
  assign cmd_o       = q_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (push) q_q[wr_q] <= c;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= 2'd0;
      rd_q  <= 1'b0;
      wr_q  <= 1'b0;
    end else begin
      if (push) wr_q <= ~wr_q;
      if (cmd_pop_i) rd_q <= ~rd_q;
      cnt_q <= cnt_q + 2'(push) - 2'(cmd_pop_i);
    end
  end
endmodule
`default_nettype wire

[src/ogic_back.sv]
// Back end: union-find sequencer over land, parent and rank memories.
`timescale 1ns / 1ps
`default_nettype none
module ogic_back import ogic_pkg::*; #(
  parameter int unsigned MaxRows = MaxRowsDef,
  parameter int unsigned MaxCols = MaxColsDef
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic [CfgW-1:0]   rows_i,
  input  wire logic [CfgW-1:0]   cols_i,
  input  wire logic              cmd_valid_i,
  output logic                   cmd_pop_o,
  input  ogic_cmd_t              cmd_i,
  output logic                   out_valid_o,
  input  wire logic              out_stall_i,
  output logic [CountW-1:0]      count_o,
  output logic                   oor_o,
  output logic                   busy_o
);
  localparam int unsigned Cells = MaxRows * MaxCols;
  localparam int unsigned AW = $clog2(Cells) > 0 ? $clog2(Cells) : 1;
  localparam int unsigned RW = 4;
  localparam int unsigned RowLimW = $clog2(MaxRows + 1) > CfgW ? $clog2(MaxRows + 1) : CfgW;
  localparam int unsigned ColLimW = $clog2(MaxCols + 1) > CfgW ? $clog2(MaxCols + 1) : CfgW;

  localparam logic [3:0] SClr = 4'd0, SIdle = 4'd1, SLand = 4'd2, SNbr = 4'd3,
                         SNLand = 4'd4, SFind = 4'd5, SFindW = 4'd6, SComp = 4'd7,
                         SCompW = 4'd8, SRank = 4'd9, SRankW = 4'd10, SLink = 4'd11,
                         SOut = 4'd12;

  logic [3:0] st_q, st_d;
  logic [AW-1:0] clr_q;
  logic [AW-1:0] node_q, adj_q, cur_q, ra_q, root_q;
  logic [4:0] r_q, c_q;
  logic [1:0] dir_q;
  logic phase_q;          // 0: finding root of node, 1: of neighbor
  logic [RW-1:0] rka_q;
  logic [CountW-1:0] cnt_q;
  logic ov_q, oor_q;
  logic [CountW-1:0] oc_q;

  // Memory ports
  logic we_l, we_p, we_r;
  logic [AW-1:0] a_l, a_p, a_r, wd_p;
  logic wd_l, rd_l;
  logic [AW-1:0] rd_p;
  logic [RW-1:0] wd_r, rd_r;

  ogic_ram #(.Width(1), .Depth(Cells)) u_land
    (.clk_i, .we_i(we_l), .addr_i(a_l), .wdata_i(wd_l), .rdata_o(rd_l));
  ogic_ram #(.Width(AW), .Depth(Cells)) u_par
    (.clk_i, .we_i(we_p), .addr_i(a_p), .wdata_i(wd_p), .rdata_o(rd_p));
  ogic_ram #(.Width(RW), .Depth(Cells)) u_rank
    (.clk_i, .we_i(we_r), .addr_i(a_r), .wdata_i(wd_r), .rdata_o(rd_r));

  logic [RowLimW-1:0] rlim;
  logic [ColLimW-1:0] clim;
  logic nok;
  logic [5:0] nr, nc;
  always_comb begin
    rlim = (RowLimW'(rows_i) > RowLimW'(MaxRows)) ? RowLimW'(MaxRows) : RowLimW'(rows_i);
    clim = (ColLimW'(cols_i) > ColLimW'(MaxCols)) ? ColLimW'(MaxCols) : ColLimW'(cols_i);
    nr = {1'b0, r_q};
    nc = {1'b0, c_q};
    case (dir_q)
      2'd0: nr = {1'b0, r_q} + 6'd1;
      2'd1: nc = {1'b0, c_q} + 6'd1;
      2'd2: nr = {1'b0, r_q} - 6'd1;
      default: nc = {1'b0, c_q} - 6'd1;
    endcase
    nok = !nr[5] && !nc[5] && (RowLimW'(nr) < rlim) && (ColLimW'(nc) < clim);
  end

  function automatic logic [AW-1:0] idx(input logic [5:0] r, input logic [5:0] c);
    idx = AW'(32'(r) * MaxCols + 32'(c));
  endfunction

  always_comb begin
    st_d = st_q;
    we_l = 1'b0; a_l = node_q; wd_l = 1'b1;
    we_p = 1'b0; a_p = cur_q; wd_p = root_q;
    we_r = 1'b0; a_r = ra_q; wd_r = rka_q + RW'(1);
    cmd_pop_o = 1'b0;
    case (st_q)
      // The clearing pass empties the land map, zeroes ranks and points every
      // parent entry at itself.
      SClr: begin
        we_l = 1'b1; a_l = clr_q; wd_l = 1'b0;
        we_p = 1'b1; a_p = clr_q; wd_p = clr_q;
        we_r = 1'b1; a_r = clr_q; wd_r = '0;
        if (clr_q == AW'(Cells - 1)) st_d = SIdle;
      end
      SIdle: if (cmd_valid_i && !ov_q) begin
        cmd_pop_o = 1'b1;
        a_l = idx({1'b0, cmd_i.row}, {1'b0, cmd_i.col});
        st_d = cmd_i.oor ? SOut : SLand;
      end
      SLand: if (rd_l) st_d = SOut;
        else begin
          we_l = 1'b1;
          st_d = SNbr;
        end
      SNbr: begin
        a_l = idx(nr, nc);
        st_d = nok ? SNLand : (dir_q == 2'd3 ? SOut : SNbr);
      end
      SNLand: begin
        a_p = node_q;
        st_d = rd_l ? SFindW : (dir_q == 2'd3 ? SOut : SNbr);
      end
      SFind: begin
        a_p = cur_q;
        st_d = SFindW;
      end
      SFindW: begin
        a_p = rd_p;
        st_d = (rd_p == cur_q) ? SComp : SFindW;
      end
      SComp: begin
        a_p = cur_q;
        st_d = SCompW;
      end
      // Each compressed link is rewritten here; the next parent is then read in
      // SComp.
      SCompW: begin
        a_p = cur_q;
        if (cur_q == root_q) begin
          st_d = phase_q ? SRank : SFind;
        end else begin
          we_p = 1'b1;
          wd_p = root_q;
          st_d = SComp;
        end
      end
      SRank: begin
        a_r = ra_q;
        st_d = (ra_q == root_q) ? (dir_q == 2'd0 ? SOut : SNbr) : SRankW;
      end
      SRankW: begin
        a_r = root_q;
        st_d = SLink;
      end
      SLink: begin
        if (rka_q > rd_r) begin
          we_p = 1'b1; a_p = root_q; wd_p = ra_q;
        end else if (rka_q < rd_r) begin
          we_p = 1'b1; a_p = ra_q; wd_p = root_q;
        end else begin
          we_p = 1'b1; a_p = root_q; wd_p = ra_q;
          we_r = 1'b1; a_r = ra_q; wd_r = rka_q + RW'(1);
        end
        st_d = (dir_q == 2'd0) ? SOut : SNbr;
      end
      SOut: st_d = SIdle;
      default: st_d = SIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= SClr; clr_q <= '0; cnt_q <= '0; ov_q <= 1'b0;
      dir_q <= 2'd0; phase_q <= 1'b0;
      r_q <= '0; c_q <= '0; oor_q <= 1'b0; oc_q <= '0;
      node_q <= '0; adj_q <= '0; cur_q <= '0; ra_q <= '0; root_q <= '0;
      rka_q <= '0;
    end else begin
      st_q <= st_d;
      if (ov_q && !out_stall_i) ov_q <= 1'b0;
      case (st_q)
        SClr: clr_q <= clr_q + AW'(1);
        SIdle: if (cmd_valid_i && !ov_q) begin
          r_q <= cmd_i.row; c_q <= cmd_i.col; oor_q <= cmd_i.oor;
          node_q <= idx({1'b0, cmd_i.row}, {1'b0, cmd_i.col});
          dir_q <= 2'd0;
        end
        SLand: if (!rd_l) cnt_q <= cnt_q + CountW'(1);
        SNbr: begin
          adj_q <= idx(nr, nc);
          if (!nok) dir_q <= dir_q + 2'd1;
        end
        SNLand: begin
          dir_q <= dir_q + 2'd1;
          cur_q <= node_q; phase_q <= 1'b0;
        end
        SFind: ;
        SFindW: if (rd_p == cur_q) cur_q <= phase_q ? adj_q : node_q;
          else cur_q <= rd_p;
        SComp: ;
        SCompW: begin
          if (cur_q == root_q) begin
            if (!phase_q) begin
              ra_q <= root_q; phase_q <= 1'b1; cur_q <= adj_q;
            end
          end else cur_q <= rd_p;
        end
        SRank: ;
        SRankW: rka_q <= rd_r;
        SLink: cnt_q <= cnt_q - CountW'(1);
        SOut: begin
          ov_q <= 1'b1; oc_q <= cnt_q;
        end
        default: ;
      endcase
      if (st_q == SFindW && rd_p == cur_q) root_q <= cur_q;
    end
  end

  assign busy_o = (st_q != SIdle) || ov_q;

  assign out_valid_o = ov_q;
  assign count_o = oc_q;
  assign oor_o = oor_q;
endmodule
`default_nettype wire

[src/online_grid_island_counter_core.sv]
// Top level of the online grid island counter.
// A cell out of range or already land is answered without visiting neighbors; a new
// land cell visits each neighbor in the grid and, for each land neighbor, finds both
// roots with path compression and links them by rank unless they share a set.
// One transaction is in the back end at a time; the next starts the cycle after
// the previous result is taken. After reset a clearing pass over all
// MAX_ROWS*MAX_COLS memory entries runs before any item is processed.
`timescale 1ns / 1ps
`default_nettype none
module online_grid_island_counter_core import ogic_pkg::*; #(
  parameter int unsigned MaxRows = MaxRowsDef,
  parameter int unsigned MaxCols = MaxColsDef
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              cfg_we_i,
  input  wire logic              cfg_index_i,
  input  wire logic [CfgW-1:0]   cfg_wdata_i,
  input  wire logic              in_valid_i,
  output logic                   in_stall_o,
  input  wire logic [4:0]        cell_row_i,
  input  wire logic [4:0]        cell_col_i,
  output logic                   out_valid_o,
  input  wire logic              out_stall_i,
  output logic [CountW-1:0]      island_count_o,
  output logic                   out_of_range_o
);
  logic [CfgW-1:0] rows_q, cols_q;
  logic cmd_valid, cmd_pop, busy;
  ogic_cmd_t cmd;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rows_q <= CfgW'(32);
      cols_q <= CfgW'(32);
    end else if (cfg_we_i) begin
      if (cfg_index_i == CfgRows) rows_q <= cfg_wdata_i;
      else cols_q <= cfg_wdata_i;
    end
  end

  ogic_front #(.MaxRows(MaxRows), .MaxCols(MaxCols)) u_front (
    .clk_i, .rst_ni, .rows_i(rows_q), .cols_i(cols_q),
    .in_valid_i, .in_stall_o, .row_i(cell_row_i), .col_i(cell_col_i),
    .cmd_valid_o(cmd_valid), .cmd_pop_i(cmd_pop), .cmd_o(cmd));

  ogic_back #(.MaxRows(MaxRows), .MaxCols(MaxCols)) u_back (
    .clk_i, .rst_ni, .rows_i(rows_q), .cols_i(cols_q),
    .cmd_valid_i(cmd_valid), .cmd_pop_o(cmd_pop), .cmd_i(cmd),
    .out_valid_o, .out_stall_i, .count_o(island_count_o), .oor_o(out_of_range_o),
    .busy_o(busy));

`ifndef SYNTHESIS
  a_pop_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_pop |-> cmd_valid) else $error("pop from empty queue");
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(island_count_o))
    else $error("result changed under stall");
  a_busy_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> busy) else $error("result without busy back end");
`endif
endmodule
`default_nettype wire

[verif/testbench.sv]
// Self-checking testbench for the online grid island counter core.
`timescale 1ns / 1ps
`default_nettype none

class island_scoreboard;
  logic        land[1024];
  int unsigned link[1024];
  int unsigned rnk[1024];
  int unsigned islands;
  int unsigned rows_cfg;
  int unsigned cols_cfg;
  logic [10:0] exp_count_q[$];
  logic        exp_oor_q[$];
  int          errors;
  int          checked;
  int          oor_seen;

  function void clear();
    for (int i = 0; i < 1024; i++) begin
      land[i] = 1'b0;
      link[i] = i;
      rnk[i] = 0;
    end
    islands = 0;
    rows_cfg = 32;
    cols_cfg = 32;
    errors = 0;
    checked = 0;
    oor_seen = 0;
  endfunction

  function void write_reg(logic idx, logic [5:0] val);
    if (idx == ogic_pkg::CfgRows) begin
      rows_cfg = val;
    end else begin
      cols_cfg = val;
    end
  endfunction

  function int unsigned find_root(int unsigned n);
    int unsigned r;
    int unsigned cur;
    int unsigned nxt;
    r = n;
    while (link[r] != r) r = link[r];
    cur = n;
    while (cur != r) begin
      nxt = link[cur];
      link[cur] = r;
      cur = nxt;
    end
    return r;
  endfunction

  function bit merge_sets(int unsigned a, int unsigned b);
    int unsigned ra;
    int unsigned rb;
    ra = find_root(a);
    rb = find_root(b);
    if (ra == rb) return 0;
    if (rnk[ra] > rnk[rb]) begin
      link[rb] = ra;
    end else if (rnk[ra] < rnk[rb]) begin
      link[ra] = rb;
    end else begin
      link[rb] = ra;
      rnk[ra] = (rnk[ra] + 1) & 8'hff;
    end
    return 1;
  endfunction

  function void queue_expected(logic [10:0] cnt, logic oor);
    exp_count_q = {exp_count_q, cnt};
    exp_oor_q = {exp_oor_q, oor};
  endfunction

  // Applies one accepted cell and queues the island count it must produce.
  function void note_cell(logic [4:0] r, logic [4:0] c);
    int unsigned rows;
    int unsigned cols;
    int unsigned node;
    int nr;
    int nc;
    int dr[4] = '{1, 0, -1, 0};
    int dc[4] = '{0, 1, 0, -1};
    rows = rows_cfg > 32 ? 32 : rows_cfg;
    cols = cols_cfg > 32 ? 32 : cols_cfg;
    if (r >= rows || c >= cols) begin
      queue_expected(islands[10:0], 1'b1);
      return;
    end
    node = r * 32 + c;
    if (!land[node]) begin
      land[node] = 1'b1;
      islands++;
      for (int d = 0; d < 4; d++) begin
        nr = int'(r) + dr[d];
        nc = int'(c) + dc[d];
        if (nr < 0 || nc < 0 || nr >= int'(rows) || nc >= int'(cols)) continue;
        if (land[nr * 32 + nc] && merge_sets(node, nr * 32 + nc)) islands--;
      end
    end
    queue_expected(islands[10:0], 1'b0);
  endfunction

  function void check_result(logic [10:0] cnt, logic oor);
    logic [10:0] ec;
    logic        eo;
    if (exp_count_q.size() == 0) begin
      $display("%0t: unexpected result count=%0d oor=%0b", $time, cnt, oor);
      errors++;
      return;
    end
    ec = exp_count_q.pop_front();
    eo = exp_oor_q.pop_front();
    checked++;
    if (eo) oor_seen++;
    if (cnt !== ec) begin
      $display("%0t: island_count expected %0d actual %0d", $time, ec, cnt);
      errors++;
    end
    if (oor !== eo) begin
      $display("%0t: out_of_range expected %0b actual %0b", $time, eo, oor);
      errors++;
    end
  endfunction
endclass

module testbench;
  import ogic_pkg::*;

  logic              clk;
  logic              rst_n;
  logic              cfg_we;
  logic              cfg_index;
  logic [CfgW-1:0]   cfg_wdata;
  logic              in_valid;
  logic              in_stall;
  logic [4:0]        cell_row;
  logic [4:0]        cell_col;
  logic              out_valid;
  logic              out_stall;
  logic [CountW-1:0] island_count;
  logic              out_of_range;

  island_scoreboard grid_sb;
  bit  sink_idle_ok;
  bit  long_hold;
  int  sent;

  online_grid_island_counter_core u_top (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .cfg_we_i      (cfg_we),
    .cfg_index_i   (cfg_index),
    .cfg_wdata_i   (cfg_wdata),
    .in_valid_i    (in_valid),
    .in_stall_o    (in_stall),
    .cell_row_i    (cell_row),
    .cell_col_i    (cell_col),
    .out_valid_o   (out_valid),
    .out_stall_i   (out_stall),
    .island_count_o(island_count),
    .out_of_range_o(out_of_range)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #40ms;
    $display("== FAIL ==");
    $finish;
  end

  // Result side: checks every transaction and stalls in random bursts or one long hold.
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      grid_sb.check_result(island_count, out_of_range);
    end
  end

  initial begin
    int burst;
    out_stall = 1'b0;
    @(posedge rst_n);
    forever begin
      @(posedge clk);
      if (long_hold) begin
        out_stall <= 1'b1;
        repeat (300) @(posedge clk);
        out_stall <= 1'b0;
        long_hold = 1'b0;
      end else if (sink_idle_ok && $urandom_range(0, 5) == 0) begin
        burst = $urandom_range(1, 8);
        out_stall <= 1'b1;
        repeat (burst - 1) @(posedge clk);
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  task automatic send_cell(logic [4:0] r, logic [4:0] c, bit gaps);
    int burst;
    if (gaps && $urandom_range(0, 5) == 0) begin
      burst = $urandom_range(1, 8);
      in_valid <= 1'b0;
      repeat (burst) @(posedge clk);
    end
    in_valid <= 1'b1;
    cell_row <= r;
    cell_col <= c;
    do @(posedge clk); while (in_stall);
    grid_sb.note_cell(r, c);
    sent++;
  endtask

  task automatic go_idle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (grid_sb.exp_count_q.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic write_grid(logic [5:0] rows, logic [5:0] cols);
    cfg_we <= 1'b1;
    cfg_index <= CfgRows;
    cfg_wdata <= rows;
    @(posedge clk);
    cfg_index <= CfgCols;
    cfg_wdata <= cols;
    @(posedge clk);
    cfg_we <= 1'b0;
    grid_sb.write_reg(CfgRows, rows);
    grid_sb.write_reg(CfgCols, cols);
  endtask

  // Random cells, mostly inside a window near the configured grid.
  task automatic random_cells(int n, int unsigned rows, int unsigned cols, bit gaps);
    logic [4:0] r;
    logic [4:0] c;
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(0, 9) == 0) begin
        r = 5'($urandom);
        c = 5'($urandom);
      end else begin
        r = 5'($urandom_range(0, rows == 0 ? 0 : rows - 1));
        c = 5'($urandom_range(0, cols == 0 ? 0 : cols - 1));
      end
      send_cell(r, c, gaps);
    end
  endtask

  initial begin
    grid_sb = new();
    grid_sb.clear();
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_index = CfgRows;
    cfg_wdata = '0;
    in_valid = 1'b0;
    cell_row = '0;
    cell_col = '0;
    sink_idle_ok = 1'b1;
    long_hold = 1'b0;
    sent = 0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: corners at full size, joins, repeats, out-of-range cells.
    send_cell(5'd0, 5'd0, 0);
    send_cell(5'd31, 5'd31, 0);
    send_cell(5'd0, 5'd31, 0);
    send_cell(5'd31, 5'd0, 0);
    send_cell(5'd0, 5'd0, 0);
    send_cell(5'd0, 5'd2, 0);
    send_cell(5'd1, 5'd1, 0);
    send_cell(5'd0, 5'd1, 0);
    send_cell(5'd1, 5'd0, 0);
    send_cell(5'd1, 5'd2, 0);
    go_idle();
    write_grid(6'd4, 6'd3);
    send_cell(5'd4, 5'd0, 0);
    send_cell(5'd0, 5'd3, 0);
    send_cell(5'd31, 5'd31, 0);
    send_cell(5'd2, 5'd2, 0);
    send_cell(5'd3, 5'd2, 0);
    go_idle();
    write_grid(6'd0, 6'd0);
    send_cell(5'd0, 5'd0, 0);
    go_idle();
    write_grid(6'd63, 6'd40);
    send_cell(5'd10, 5'd10, 0);
    send_cell(5'd21, 5'd21, 0);
    go_idle();
    write_grid(6'd1, 6'd1);
    send_cell(5'd0, 5'd0, 0);
    send_cell(5'd0, 5'd1, 0);
    go_idle();

    // Long receiver hold while the sender keeps offering cells.
    write_grid(6'd32, 6'd32);
    long_hold = 1'b1;
    random_cells(60, 32, 32, 0);
    go_idle();

    write_grid(6'd8, 6'd8);
    random_cells(300, 8, 8, 1);
    go_idle();
    write_grid(6'd32, 6'd1);
    random_cells(150, 32, 1, 1);
    go_idle();
    write_grid(6'd20, 6'd32);
    random_cells(450, 20, 32, 1);
    go_idle();
    write_grid(6'd5, 6'd12);
    random_cells(200, 5, 12, 1);
    go_idle();

    // Last part: no idling on either side.
    sink_idle_ok = 1'b0;
    write_grid(6'd32, 6'd32);
    random_cells(420, 32, 32, 0);
    go_idle();

    $display("Sent %0d cells over several grid sizes; %0d results checked, %0d out of range.",
             sent, grid_sb.checked, grid_sb.oor_seen);
    if (grid_sb.errors == 0 && grid_sb.exp_count_q.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end
endmodule

`default_nettype wire
